// File: hw/rtl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// Used by ile_ctrl, ile_datapath and indexed_list_engine; depends on nothing.
`default_nettype none

package ile_pkg;

    // List capacity and derived widths
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int POS_W = 5;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [POS_W-1:0]   position;
        logic signed [31:0] new_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] entry_value;
        logic [4:0]         count;
    } t_out_word;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input word
        logic execute;  // apply the held command and load the result
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/ile_ctrl.sv
// Controller for the indexed list engine: input hold state and result valid.
// Depends on ile_pkg for the datapath command struct.
`default_nettype none

module ile_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output ile_pkg::t_dp_cmd  o_dp_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic load, execute;

    // Handshake decode: execute once the result register is free or draining
    assign load    = i_in_valid && (r_state == ST_IDLE);
    assign execute = (r_state == ST_HOLD) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (load) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (execute) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result valid: set by execute, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (execute) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall       = (r_state == ST_HOLD);
    assign o_out_valid      = r_out_valid;
    assign o_dp_cmd.load    = load;
    assign o_dp_cmd.execute = execute;

`ifndef NO_ASSERTIONS
    // Every executed word shows up as a result
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        execute |=> r_out_valid)
        else $error("executed word did not produce a result");

    // An accepted word is held until executed
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_state == ST_HOLD))
        else $error("accepted word not held");

    // No execute overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !execute)
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/ile_datapath.sv
// Datapath for the indexed list engine: input register, shifting entry cells,
// entry count and result register. Depends on ile_pkg.
`default_nettype none

module ile_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ile_pkg::t_dp_cmd  i_dp_cmd,
    input  wire ile_pkg::t_in_word i_in_word,
    output ile_pkg::t_out_word     o_out_word
);

    ile_pkg::t_in_word  r_in;
    ile_pkg::t_out_word r_out, n_out;

    logic [31:0]               r_cells [ile_pkg::DEPTH];
    logic [31:0]               n_cells [ile_pkg::DEPTH];
    logic [ile_pkg::CNT_W-1:0] r_count, n_count;

    logic [ile_pkg::CMP_W-1:0] pos_x, cnt_x;
    logic [ile_pkg::IDX_W-1:0] idx;
    logic                      in_list, ins_ok, rem_ok, is_full;
    logic [31:0]               read_word;

    // Position checks against the current count
    assign pos_x     = ile_pkg::CMP_W'(r_in.position);
    assign cnt_x     = ile_pkg::CMP_W'(r_count);
    assign idx       = ile_pkg::IDX_W'(pos_x);
    assign in_list   = (pos_x < cnt_x);
    assign is_full   = (cnt_x == ile_pkg::CMP_W'(ile_pkg::DEPTH));
    assign ins_ok    = (r_in.cmd == ile_pkg::CMD_INSERT) && (pos_x <= cnt_x) && !is_full;
    assign rem_ok    = (r_in.cmd == ile_pkg::CMD_REMOVE) && in_list;
    assign read_word = r_cells[idx];

    // Cell update: each cell keeps its value, takes the new value, or takes its neighbour below or above
    always_comb begin
        for (int i = 0; i < ile_pkg::DEPTH; i++) begin
            n_cells[i] = r_cells[i];
            if (ins_ok) begin
                if (ile_pkg::CMP_W'(i) == pos_x) begin
                    n_cells[i] = r_in.new_value;
                end else if ((ile_pkg::CMP_W'(i) > pos_x) && (i > 0)) begin
                    n_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
                end
            end else if (rem_ok) begin
                if ((ile_pkg::CMP_W'(i) >= pos_x) && (i < ile_pkg::DEPTH - 1)) begin
                    n_cells[i] = r_cells[(i < ile_pkg::DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    // Count and result word
    always_comb begin
        n_count           = r_count;
        n_out.status      = ile_pkg::ST_RANGE;
        n_out.entry_value = '0;
        case (r_in.cmd)
            ile_pkg::CMD_INSERT: begin
                if (pos_x > cnt_x) begin
                    n_out.status = ile_pkg::ST_RANGE;
                end else if (is_full) begin
                    n_out.status = ile_pkg::ST_FULL;
                end else begin
                    n_out.status = ile_pkg::ST_DONE;
                    n_count      = r_count + 1'b1;
                end
            end
            ile_pkg::CMD_REMOVE: begin
                if (in_list) begin
                    n_out.status      = ile_pkg::ST_DONE;
                    n_out.entry_value = read_word;
                    n_count           = r_count - 1'b1;
                end
            end
            ile_pkg::CMD_READ: begin
                if (in_list) begin
                    n_out.status      = ile_pkg::ST_DONE;
                    n_out.entry_value = read_word;
                end
            end
            default: n_out.status = ile_pkg::ST_RANGE;
        endcase
        n_out.count = 5'(n_count);
    end

    // Control state: entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.execute) begin
            r_count <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_dp_cmd.execute) begin
            r_out   <= n_out;
            r_cells <= n_cells;
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/indexed_list_engine.sv
// Top level of the indexed list engine: joins controller and datapath.
// Depends on ile_pkg, ile_ctrl and ile_datapath.
//
//   channel | valid       | stall       | word
//   input   | i_in_valid  | o_in_stall  | i_in_word  (cmd, position, new_value)
//   output  | o_out_valid | i_out_stall | o_out_word (status, entry_value, count)
//
// A word is taken into the input register while idle and held until it is executed:
// all entry cells shift in parallel and the result word is registered at execute,
// and no new word is taken while one is held.
// Execution waits only while a finished result is stalled at the output.
// Synchronous active-low reset empties the list; entry cells are not cleared.
`default_nettype none

module indexed_list_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ile_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ile_pkg::t_out_word      o_out_word
);

    ile_pkg::t_dp_cmd dp_cmd;

    ile_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (dp_cmd)
    );

    ile_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dp_cmd   (dp_cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire
